@@ rtl/psel_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psel_pkg
// Shared types and constants for the proportional share selector.
// ----------------------------------------------------------------------------
package psel_pkg;

	localparam int MAX_CLASSES = 4;
	localparam int CLS_W       = 2;
	localparam int CNT_W       = 10;
	localparam int CCNT_W      = 3;
	localparam int W_W         = 8;
	localparam int SUM_W       = 12;
	localparam int PROD_W      = W_W + SUM_W;
	localparam int SCORE_W     = PROD_W + 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ALIVE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_WEIGHTS = 2'd2;

	// item opcodes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic             op;
		logic [CLS_W-1:0] release_class;
	} item_t;

	typedef struct packed {
		logic             granted;
		logic [CLS_W-1:0] granted_class;
		logic [CNT_W-1:0] live_total;
	} result_t;

	typedef logic [MAX_CLASSES-1:0][CNT_W-1:0] counts_t;

	// selector verdict: valid when at least one class is in use
	typedef struct packed {
		logic             valid;
		logic [CLS_W-1:0] cls;
	} pick_t;

endpackage
`default_nettype wire

@@ rtl/psel_pick.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psel_pick
// Largest-deficit class pick: scores w*T - 256*c per class (w alone when T is zero), first max wins.
// ----------------------------------------------------------------------------
module psel_pick (
	input  wire psel_pkg::counts_t                   counts,
	input  wire logic [psel_pkg::CFG_DATA_W-1:0]     weights,
	input  wire logic [psel_pkg::CCNT_W-1:0]         n_used,
	output psel_pkg::pick_t                          pick
);

	logic [psel_pkg::SUM_W-1:0]          total_in_use;
	logic signed [psel_pkg::SCORE_W-1:0] score [psel_pkg::MAX_CLASSES];
	logic [psel_pkg::PROD_W-1:0]         prod  [psel_pkg::MAX_CLASSES];
	logic signed [psel_pkg::SCORE_W-1:0] best;
	logic [psel_pkg::CLS_W-1:0]          best_cls;

	// live sum over classes in use
	always_comb begin
		total_in_use = '0;
		for (int i = 0; i < psel_pkg::MAX_CLASSES; i++) begin
			if (psel_pkg::CCNT_W'(i) < n_used) begin
				total_in_use = total_in_use + psel_pkg::SUM_W'(counts[i]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < psel_pkg::MAX_CLASSES; i++) begin
			prod[i] = psel_pkg::PROD_W'(weights[psel_pkg::W_W*i +: psel_pkg::W_W])
				* psel_pkg::PROD_W'(total_in_use);
			if (total_in_use == '0) begin
				score[i] = $signed(psel_pkg::SCORE_W'(weights[psel_pkg::W_W*i +: psel_pkg::W_W]));
			end else begin
				score[i] = $signed({1'b0, prod[i]})
					- $signed({3'b000, counts[i], 8'h00});
			end
		end
	end

	// strict greater-than keeps the lowest index on ties
	always_comb begin
		best     = score[0];
		best_cls = '0;
		for (int i = 1; i < psel_pkg::MAX_CLASSES; i++) begin
			if ((psel_pkg::CCNT_W'(i) < n_used) && (score[i] > best)) begin
				best     = score[i];
				best_cls = psel_pkg::CLS_W'(i);
			end
		end
	end

	assign pick.valid = (n_used != '0);
	assign pick.cls   = best_cls;

endmodule
`default_nettype wire

@@ rtl/proportional_share_selector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// proportional_share_selector
// Live-count tracker that grants ticks to the class furthest below its share.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while item_stall is low and returns exactly
// one result beat per item (input register, then result register). A
// tick beat grants a selection when classes are in use and the live total
// is below target_alive; the granted class is the one with the largest
// w*T - 256*c (T = live sum over classes in use, or weight alone when T is
// zero), lowest index on ties. A release beat decrements the named class
// and the total, both saturating at zero. The per-class counts and the
// total update in the same cycle the item leaves the input register, so
// the next item always sees them; the limiting path is the four 8x12
// products and the compare chain in psel_pick. Config registers are
// written via cfg_wr_en/cfg_index/cfg_wdata by the user while the block
// is idle (unenforced); index 3 is ignored. Counts and config reset to zero.
// ----------------------------------------------------------------------------
module proportional_share_selector (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// config port
	input  wire logic                                  cfg_wr_en,
	input  wire logic [psel_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [psel_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	// item channel
	input  wire logic                                  item_valid,
	output logic                                       item_stall,
	input  wire psel_pkg::item_t                       item,
	// result channel
	output logic                                       result_valid,
	input  wire logic                                  result_stall,
	output psel_pkg::result_t                          result
);

	// config registers
	logic [psel_pkg::CCNT_W-1:0]     class_count_q;
	logic [psel_pkg::CNT_W-1:0]      target_alive_q;
	logic [psel_pkg::CFG_DATA_W-1:0] class_weights_q;

	// state
	psel_pkg::counts_t               per_class_q;
	logic [psel_pkg::CNT_W-1:0]      total_q;

	// input stage
	logic                            valid_s1;
	psel_pkg::item_t                 item_s1;

	// result stage
	logic                            result_valid_q;
	psel_pkg::result_t               result_q;

	logic                            out_free;
	logic                            adv_s1;
	logic [psel_pkg::CCNT_W-1:0]     n_used;
	psel_pkg::pick_t                 pick;
	logic                            is_release;
	logic                            grant;
	logic [psel_pkg::CNT_W-1:0]      total_next;

	// ---------------- config ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q   <= '0;
			target_alive_q  <= '0;
			class_weights_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				psel_pkg::REG_CLASS_COUNT:   class_count_q   <= cfg_wdata[psel_pkg::CCNT_W-1:0];
				psel_pkg::REG_TARGET_ALIVE:  target_alive_q  <= cfg_wdata[psel_pkg::CNT_W-1:0];
				psel_pkg::REG_CLASS_WEIGHTS: class_weights_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// oversized class_count clamps to the class ceiling
	assign n_used = (class_count_q > psel_pkg::CCNT_W'(psel_pkg::MAX_CLASSES))
		? psel_pkg::CCNT_W'(psel_pkg::MAX_CLASSES) : class_count_q;

	// ---------------- handshake ----------------
	// result register frees when empty or being taken this cycle
	assign out_free   = !result_valid_q || !result_stall;
	assign adv_s1     = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// ---------------- selection ----------------
	psel_pick u_pick (
		.counts  (per_class_q),
		.weights (class_weights_q),
		.n_used  (n_used),
		.pick    (pick)
	);

	assign is_release = (item_s1.op == psel_pkg::OP_RELEASE);
	assign grant      = !is_release && pick.valid && (total_q < target_alive_q);

	always_comb begin
		total_next = total_q;
		if (is_release) begin
			if (total_q != '0) begin
				total_next = total_q - 1'b1;
			end
		end else if (grant) begin
			total_next = total_q + 1'b1;
		end
	end

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_class_q <= '0;
			total_q     <= '0;
		end else if (adv_s1) begin
			total_q <= total_next;
			for (int i = 0; i < psel_pkg::MAX_CLASSES; i++) begin
				if (is_release && (item_s1.release_class == psel_pkg::CLS_W'(i))) begin
					if (per_class_q[i] != '0) begin
						per_class_q[i] <= per_class_q[i] - 1'b1;
					end
				end else if (grant && (pick.cls == psel_pkg::CLS_W'(i))) begin
					if (per_class_q[i] != psel_pkg::CNT_MAX) begin
						per_class_q[i] <= per_class_q[i] + 1'b1;
					end
				end
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q.granted       <= grant;
			result_q.granted_class <= grant ? pick.cls : '0;
			result_q.live_total    <= total_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// a grant only happens below the target
	a_grant_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && grant |-> total_q < target_alive_q)
		else $error("grant with live total at or above target");

	// granted class must be one in use
	a_grant_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && grant |-> psel_pkg::CCNT_W'(pick.cls) < n_used)
		else $error("granted class not in use");

	// release never raises the total, and saturates at zero
	a_release_total: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && is_release |=>
			(($past(total_q) == '0) && (total_q == '0)) ||
			(($past(total_q) != '0) && (total_q == $past(total_q) - 1'b1)))
		else $error("release total update wrong");

	// input stalls only with a held item behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid_q && result_stall)
		else $error("input stalled without cause");
`endif

endmodule
`default_nettype wire
